>>> hw/rtl/waypoint_follower_turn_then_drive_top_macros.svh
// ----------------------------------------------------------------------------
// Waypoint follower assertion macros
// Shared property wrappers for the concurrent checks of the top level.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_FOLLOWER_TURN_THEN_DRIVE_TOP_MACROS_SVH
`define WAYPOINT_FOLLOWER_TURN_THEN_DRIVE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define WFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/wft_pkg.sv
// ----------------------------------------------------------------------------
// Waypoint follower package
// Types, constants and tables shared by the controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wft_pkg;

  // Waypoint table
  localparam int MAX_WAYPOINTS = 256;
  localparam int WP_AW         = $clog2(MAX_WAYPOINTS);

  // CORDIC sizing: inputs are scaled up by powers of two until the larger magnitude reaches 2^40
  localparam int CIN          = 35;
  localparam int CW           = 44;
  localparam int NORM_LIM     = 40;
  localparam int NORM_STEP    = 8;
  localparam int NORM_COARSE  = NORM_LIM - NORM_STEP;
  localparam int CORDIC_ITERS = 24;
  localparam int ANG_FRAC     = 13;
  localparam int QUARTER_TURN = 90 << 20;
  localparam int YAW_ONE      = 1 << 28;

  // Distance / square root
  localparam int DW       = 33;
  localparam int SUM_W    = 2 * DW;
  localparam int SQ_STEPS = 6;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_ENABLE    = 3'd0,
    REG_POS_THR   = 3'd1,
    REG_ANG_THR   = 3'd2,
    REG_TURN_SPD  = 3'd3,
    REG_GAIN      = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_TURN  = 2'd1,
    RES_DRIVE = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         slot;
    logic [8:0]         path_length;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } item_t;

  typedef struct packed {
    logic               cmd_valid;
    logic [30:0]        linear_velocity;
    logic signed [31:0] angular_velocity;
    logic               waypoint_reached;
    logic               goal_reached;
    logic [8:0]         remaining_waypoints;
  } result_t;

  // Controller -> datapath
  typedef struct packed {
    logic             load;
    logic             wr;
    logic             rd;
    logic [WP_AW-1:0] rd_addr;
    logic             diff;
    logic             cordic_start;
    logic             brg_sel;
    logic             store_brg;
    logic             sqrt_start;
    logic             mul;
    logic             emit;
    res_kind_t        kind;
    logic             reached;
    logic             goal;
    logic [8:0]       remaining;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic enable;
    logic out_free;
    logic cordic_done;
    logic sqrt_done;
    logic far;
    logic dxy_nz;
    logic turn_ok;
  } dp_status_t;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic [25:0] atan_tab(input logic [4:0] i);
    logic [25:0] v;
    unique case (i)
      5'd0:  v = 26'd47185920;
      5'd1:  v = 26'd27855475;
      5'd2:  v = 26'd14718068;
      5'd3:  v = 26'd7471121;
      5'd4:  v = 26'd3750058;
      5'd5:  v = 26'd1876857;
      5'd6:  v = 26'd938658;
      5'd7:  v = 26'd469357;
      5'd8:  v = 26'd234682;
      5'd9:  v = 26'd117342;
      5'd10: v = 26'd58671;
      5'd11: v = 26'd29335;
      5'd12: v = 26'd14668;
      5'd13: v = 26'd7334;
      5'd14: v = 26'd3667;
      5'd15: v = 26'd1833;
      5'd16: v = 26'd917;
      5'd17: v = 26'd458;
      5'd18: v = 26'd229;
      5'd19: v = 26'd115;
      5'd20: v = 26'd57;
      5'd21: v = 26'd29;
      5'd22: v = 26'd14;
      5'd23: v = 26'd7;
      default: v = 26'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/wft_in_if.sv
// ----------------------------------------------------------------------------
// Waypoint follower input channel
// Valid/ready channel carrying one input item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wft_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [7:0]         slot;
  logic [8:0]         path_length;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, action, slot, path_length, pos_x, pos_y,
                  quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, action, slot, path_length, pos_x, pos_y,
                quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

>>> hw/rtl/wft_out_if.sv
// ----------------------------------------------------------------------------
// Waypoint follower result channel
// Valid/ready channel carrying one velocity command result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wft_out_if;
  logic               valid;
  logic               ready;
  logic               cmd_valid;
  logic [30:0]        linear_velocity;
  logic signed [31:0] angular_velocity;
  logic               waypoint_reached;
  logic               goal_reached;
  logic [8:0]         remaining_waypoints;

  modport source (output valid, cmd_valid, linear_velocity, angular_velocity,
                  waypoint_reached, goal_reached, remaining_waypoints,
                  input ready);
  modport sink (input valid, cmd_valid, linear_velocity, angular_velocity,
                waypoint_reached, goal_reached, remaining_waypoints,
                output ready);
endinterface

>>> hw/rtl/wft_cfg_if.sv
// ----------------------------------------------------------------------------
// Waypoint follower configuration channel
// Register write channel: index and data under valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wft_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/wft_ctrl.sv
// ----------------------------------------------------------------------------
// Waypoint follower controller
// Sequences each item and owns the path state (count, turn and goal flags).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wft_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  wft_pkg::item_t     item,
  input  wft_pkg::dp_status_t st,
  output wft_pkg::ctrl_cmd_t cmd
);
  import wft_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_READ = 8'b0000_0010,
    S_DIFF = 8'b0000_0100,
    S_YAW  = 8'b0000_1000,
    S_BRG  = 8'b0001_0000,
    S_DIST = 8'b0010_0000,
    S_MUL  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_START  = 3'd1,
    OP_GOAL   = 3'd2,
    OP_TURN   = 3'd3,
    OP_DRIVE  = 3'd4,
    OP_ARRIVE = 3'd5
  } op_t;

  state_t     state, state_next;
  op_t        op, op_next;
  logic [8:0] plen_sat;
  logic [8:0] remaining;
  logic       path_ready, turn_done, goal_done;

  logic       accept, active;
  logic [8:0] rem_n;
  logic       goal_n, turn_n, ready_n;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign active     = st.enable && path_ready && !goal_done;

  // Next state and datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    op_next    = op;
    rem_n      = remaining;
    goal_n     = goal_done;
    turn_n     = turn_done;
    ready_n    = path_ready;
    cmd.rd_addr = WP_AW'(remaining - 9'd1);
    unique case (state)
      S_IDLE: begin
        cmd.load = accept;
        if (accept) begin
          state_next = S_DONE;
          op_next    = OP_NONE;
          priority if (item.action == ACT_WRITE) begin
            cmd.wr = (32'(item.slot) < MAX_WAYPOINTS);
          end else if (item.action == ACT_START) begin
            op_next = OP_START;
          end else if (item.action == ACT_TICK && active) begin
            if (remaining == 9'd0) begin
              op_next = OP_GOAL;
            end else begin
              cmd.rd     = 1'b1;
              state_next = S_READ;
            end
          end else begin
            op_next = OP_NONE;
          end
        end
      end
      S_READ: begin
        cmd.diff   = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        priority if (!turn_done) begin
          cmd.cordic_start = 1'b1;
          op_next          = OP_TURN;
          state_next       = S_YAW;
        end else if (st.far) begin
          cmd.sqrt_start = 1'b1;
          op_next        = OP_DRIVE;
          state_next     = S_DIST;
        end else begin
          op_next    = OP_ARRIVE;
          state_next = S_DONE;
        end
      end
      S_YAW: begin
        if (st.cordic_done) begin
          if (st.dxy_nz) begin
            cmd.cordic_start = 1'b1;
            cmd.brg_sel      = 1'b1;
            state_next       = S_BRG;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_BRG: begin
        cmd.store_brg = 1'b1;
        if (st.cordic_done) state_next = S_DONE;
      end
      S_DIST: begin
        if (st.sqrt_done) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        unique case (op)
          OP_START: begin
            ready_n = 1'b1;
            turn_n  = 1'b0;
            if (plen_sat < 9'd2) begin
              rem_n  = 9'd0;
              goal_n = 1'b1;
            end else begin
              rem_n  = plen_sat - 9'd1;
              goal_n = 1'b0;
            end
          end
          OP_GOAL: begin
            goal_n = 1'b1;
            turn_n = 1'b0;
          end
          OP_TURN: begin
            cmd.kind = RES_TURN;
            if (st.turn_ok) turn_n = 1'b1;
          end
          OP_DRIVE: cmd.kind = RES_DRIVE;
          OP_ARRIVE: begin
            rem_n       = remaining - 9'd1;
            cmd.reached = 1'b1;
            if (rem_n != 9'd0) turn_n = 1'b0;
          end
          default: ;
        endcase
        cmd.goal      = goal_n;
        cmd.remaining = rem_n;
        cmd.emit      = st.out_free;
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and path bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      op         <= OP_NONE;
      remaining  <= 9'd0;
      path_ready <= 1'b0;
      turn_done  <= 1'b0;
      goal_done  <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (cmd.emit) begin
        remaining  <= rem_n;
        path_ready <= ready_n;
        turn_done  <= turn_n;
        goal_done  <= goal_n;
      end
    end
  end

  // Saturated path length for a start transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      plen_sat <= (32'(item.path_length) > MAX_WAYPOINTS) ? 9'(MAX_WAYPOINTS)
                                                          : item.path_length;
    end
  end

endmodule

>>> hw/rtl/wft_cordic.sv
// ----------------------------------------------------------------------------
// Waypoint follower CORDIC
// Iterative atan2 in vectoring mode, result in 1/128 degree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wft_cordic (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [wft_pkg::CIN-1:0] y_in,
  input  logic signed [wft_pkg::CIN-1:0] x_in,
  output logic                        done,
  output logic signed [15:0]          angle
);
  import wft_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_NORM = 4'b0010,
    C_ITER = 4'b0100,
    C_OUT  = 4'b1000
  } cst_t;

  localparam logic [CW-1:0] LIM_COARSE = CW'(1) << NORM_COARSE;
  localparam logic [CW-1:0] LIM_FINE   = CW'(1) << NORM_LIM;

  cst_t               st;
  logic signed [CW-1:0] x, y;
  logic signed [31:0] acc;
  logic [4:0]         it;

  logic [CW-1:0]      ax, ay, m;
  logic signed [CW-1:0] xs, ys;
  logic signed [31:0] tab;
  logic [31:0]        acc_mag, rnd;
  logic signed [15:0] angle_next;

  // Magnitudes, shifted terms and rounding
  always_comb begin
    ax  = x[CW-1] ? CW'(-x) : CW'(x);
    ay  = y[CW-1] ? CW'(-y) : CW'(y);
    m   = (ax > ay) ? ax : ay;
    xs  = x >>> it;
    ys  = y >>> it;
    tab = signed'(32'(atan_tab(it)));
    acc_mag    = acc[31] ? 32'(-acc) : 32'(acc);
    rnd        = (acc_mag + 32'd4096) >> ANG_FRAC;
    angle_next = acc[31] ? -signed'(16'(rnd)) : signed'(16'(rnd));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= C_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        C_IDLE: begin
          if (start) begin
            acc <= '0;
            x   <= CW'(x_in);
            y   <= CW'(y_in);
            st  <= (x_in == '0 && y_in == '0) ? C_OUT : C_NORM;
          end
        end
        C_NORM: begin
          priority if (m < LIM_COARSE) begin
            x <= x <<< NORM_STEP;
            y <= y <<< NORM_STEP;
          end else if (m < LIM_FINE) begin
            x <= x <<< 1;
            y <= y <<< 1;
          end else begin
            // quadrant fold into the right half-plane
            if (x < 0) begin
              if (y >= 0) begin
                x   <= y;
                y   <= -x;
                acc <= 32'(QUARTER_TURN);
              end else begin
                x   <= -y;
                y   <= x;
                acc <= -32'(QUARTER_TURN);
              end
            end
            it <= '0;
            st <= C_ITER;
          end
        end
        C_ITER: begin
          if (y > 0) begin
            x   <= x + ys;
            y   <= y - xs;
            acc <= acc + tab;
          end else begin
            x   <= x - ys;
            y   <= y + xs;
            acc <= acc - tab;
          end
          it <= it + 5'd1;
          if (it == 5'(CORDIC_ITERS - 1)) st <= C_OUT;
        end
        C_OUT: begin
          angle <= angle_next;
          done  <= 1'b1;
          st    <= C_IDLE;
        end
        default: st <= C_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/wft_sqrt.sv
// ----------------------------------------------------------------------------
// Waypoint follower distance unit
// Serial sum of squares followed by a bit-by-bit integer square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wft_sqrt (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [wft_pkg::DW-1:0] a,
  input  logic [wft_pkg::DW-1:0] b,
  output logic                  done,
  output logic [wft_pkg::DW-1:0] root
);
  import wft_pkg::*;

  typedef enum logic [3:0] {
    Q_IDLE = 4'b0001,
    Q_SQ   = 4'b0010,
    Q_ROOT = 4'b0100,
    Q_OUT  = 4'b1000
  } qst_t;

  qst_t            st;
  logic [DW-1:0]   av, bv;
  logic [2:0]      step;
  logic [SUM_W-1:0] sum;
  logic [5:0]      cnt;
  logic [DW+1:0]   rem;

  logic [DW-1:0]   opnd;
  logic [16:0]     ma, mb;
  logic [33:0]     prod;
  logic [5:0]      sh;
  logic [SUM_W-1:0] addend;
  logic [DW+3:0]   rem_sh, trial;

  // One 17x17 partial product of a^2 or b^2 per cycle
  always_comb begin
    opnd = (step < 3'd3) ? av : bv;
    ma   = 17'(opnd[DW-1:16]);
    mb   = 17'(opnd[DW-1:16]);
    sh   = 6'd32;
    unique case (step)
      3'd0, 3'd3: begin
        ma = 17'(opnd[DW-1:16]);
        mb = 17'(opnd[DW-1:16]);
        sh = 6'd32;
      end
      3'd1, 3'd4: begin
        ma = 17'(opnd[DW-1:16]);
        mb = 17'(opnd[15:0]);
        sh = 6'd17;
      end
      3'd2, 3'd5: begin
        ma = 17'(opnd[15:0]);
        mb = 17'(opnd[15:0]);
        sh = 6'd0;
      end
      default: ;
    endcase
    prod   = ma * mb;
    addend = SUM_W'(prod) << sh;
    rem_sh = {rem, sum[SUM_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= Q_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        Q_IDLE: begin
          if (start) begin
            av   <= a;
            bv   <= b;
            sum  <= '0;
            step <= '0;
            st   <= Q_SQ;
          end
        end
        Q_SQ: begin
          sum  <= sum + addend;
          step <= step + 3'd1;
          if (step == 3'(SQ_STEPS - 1)) begin
            cnt  <= '0;
            rem  <= '0;
            root <= '0;
            st   <= Q_ROOT;
          end
        end
        Q_ROOT: begin
          if (rem_sh >= trial) begin
            rem  <= (DW+2)'(rem_sh - trial);
            root <= {root[DW-2:0], 1'b1};
          end else begin
            rem  <= (DW+2)'(rem_sh);
            root <= {root[DW-2:0], 1'b0};
          end
          sum <= sum << 2;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DW - 1)) st <= Q_OUT;
        end
        Q_OUT: begin
          done <= 1'b1;
          st   <= Q_IDLE;
        end
        default: st <= Q_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/wft_dp.sv
// ----------------------------------------------------------------------------
// Waypoint follower datapath
// Waypoint memory, configuration, pose arithmetic and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wft_dp (
  input  logic                clk,
  input  logic                rst,
  input  wft_pkg::item_t      item,
  input  wft_pkg::ctrl_cmd_t  cmd,
  output wft_pkg::dp_status_t st,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output wft_pkg::result_t    res,
  output logic                res_valid,
  input  logic                res_ready
);
  import wft_pkg::*;

  // Configuration registers
  logic        enable;
  logic [30:0] pos_thr;
  logic [14:0] ang_thr;
  logic [30:0] turn_speed;
  logic [15:0] gain;

  // Item and working registers
  logic signed [31:0] pos_x, pos_y;
  logic signed [31:0] p_wz, p_xy, p_yy, p_zz;
  logic [63:0]        mem [MAX_WAYPOINTS];
  logic [63:0]        rd_data;
  logic signed [DW-1:0] dx, dy;
  logic signed [15:0] yaw, brg;
  logic [48:0]        lin_prod;

  logic signed [31:0]  wp_x, wp_y;
  logic [DW-1:0]       adx, ady;
  logic signed [CIN-1:0] siny, cosy, cy_in, cx_in;
  logic signed [16:0]  err;
  logic [16:0]         aerr;
  logic [30:0]         lin_sat;
  logic signed [31:0]  ts_pos;
  logic                cordic_done, sqrt_done;
  logic signed [15:0]  angle;
  logic [DW-1:0]       root;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b1;
      pos_thr    <= 31'd13107;
      ang_thr    <= 15'd256;
      turn_speed <= 31'd19661;
      gain       <= 16'd128;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE:   enable     <= cfg_data[0];
        REG_POS_THR:  pos_thr    <= cfg_data[30:0];
        REG_ANG_THR:  ang_thr    <= cfg_data[14:0];
        REG_TURN_SPD: turn_speed <= cfg_data[30:0];
        REG_GAIN:     gain       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Waypoint memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr) mem[WP_AW'(item.slot)] <= {item.pos_x, item.pos_y};
    if (cmd.rd) rd_data <= mem[cmd.rd_addr];
  end

  // Pose capture and quaternion products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_x <= item.pos_x;
      pos_y <= item.pos_y;
      p_wz  <= item.quat_w * item.quat_z;
      p_xy  <= item.quat_x * item.quat_y;
      p_yy  <= item.quat_y * item.quat_y;
      p_zz  <= item.quat_z * item.quat_z;
    end
  end

  // Offset to the waypoint
  assign wp_x = rd_data[63:32];
  assign wp_y = rd_data[31:0];
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx <= DW'(wp_x) - DW'(pos_x);
      dy <= DW'(wp_y) - DW'(pos_y);
    end
  end

  always_comb begin
    adx  = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady  = dy[DW-1] ? DW'(-dy) : DW'(dy);
    siny = (CIN'(p_wz) + CIN'(p_xy)) <<< 1;
    cosy = CIN'(YAW_ONE) - ((CIN'(p_yy) + CIN'(p_zz)) <<< 1);
    cy_in = cmd.brg_sel ? CIN'(dy) : siny;
    cx_in = cmd.brg_sel ? CIN'(dx) : cosy;
  end

  wft_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.cordic_start),
    .y_in  (cy_in),
    .x_in  (cx_in),
    .done  (cordic_done),
    .angle (angle)
  );

  // Heading and bearing results
  always_ff @(posedge clk) begin
    if (cmd.load) brg <= '0;
    if (cordic_done) begin
      if (cmd.store_brg) brg <= angle;
      else               yaw <= angle;
    end
  end

  wft_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .a     (adx),
    .b     (ady),
    .done  (sqrt_done),
    .root  (root)
  );

  // Forward speed: gain times distance, Q8.8 scaled
  always_ff @(posedge clk) begin
    if (cmd.mul) lin_prod <= 49'(gain) * 49'(root);
  end

  always_comb begin
    err     = 17'(yaw) - 17'(brg);
    aerr    = err[16] ? 17'(-err) : 17'(err);
    lin_sat = (lin_prod[48:39] != '0) ? 31'h7FFF_FFFF : lin_prod[38:8];
    ts_pos  = signed'({1'b0, turn_speed});
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.cmd_valid           <= (cmd.kind != RES_NONE);
      res.linear_velocity     <= (cmd.kind == RES_DRIVE) ? lin_sat : '0;
      res.angular_velocity    <= (cmd.kind != RES_TURN) ? '0
                                 : (err[16] ? ts_pos : -ts_pos);
      res.waypoint_reached    <= cmd.reached;
      res.goal_reached        <= cmd.goal;
      res.remaining_waypoints <= cmd.remaining;
    end
  end

  // Status back to the controller
  always_comb begin
    st.enable      = enable;
    st.out_free    = !res_valid || res_ready;
    st.cordic_done = cordic_done;
    st.sqrt_done   = sqrt_done;
    st.far         = (adx > DW'(pos_thr)) || (ady > DW'(pos_thr));
    st.dxy_nz      = (dx != '0) && (dy != '0);
    st.turn_ok     = (aerr <= 17'(ang_thr));
  end

endmodule

>>> hw/rtl/waypoint_follower_turn_then_drive_top.sv
// ----------------------------------------------------------------------------
// Waypoint follower, turn then drive
// Loads a waypoint table, follows it and issues one velocity result per item.
// ----------------------------------------------------------------------------
// One item is worked at a time; each yields exactly one result. Waypoint
// writes, path starts and ticks that read no waypoint go straight from idle
// to the done state. A turning tick passes once or twice through the shared
// iterative CORDIC (normalize steps, then 24 rotations) for heading and
// bearing, once when the offset lies on an axis. A driving tick runs the
// serial sum of six partial products and the 33-step square root. A tick
// that arrives at a waypoint reads it and forms the offset, with no CORDIC
// or square root pass. A stalled result side holds the item in its done
// state. The result register frees the input side: the next item may enter
// while the previous result waits. The waypoint table has no reset and
// needs no clearing pass; configuration writes are taken every cycle.
`timescale 1ns / 1ps

`include "waypoint_follower_turn_then_drive_top_macros.svh"

module waypoint_follower_turn_then_drive_top (
  input logic         clk,
  input logic         rst,
  wft_in_if.sink      item,
  wft_out_if.source   result,
  wft_cfg_if.sink     cfg
);
  import wft_pkg::*;

  item_t      item_pl;
  result_t    res;
  ctrl_cmd_t  cmd;
  dp_status_t dp_st;
  logic       item_ready;

  // Pack the input transaction
  always_comb begin
    item_pl.action      = item.action;
    item_pl.slot        = item.slot;
    item_pl.path_length = item.path_length;
    item_pl.pos_x       = item.pos_x;
    item_pl.pos_y       = item.pos_y;
    item_pl.quat_x      = item.quat_x;
    item_pl.quat_y      = item.quat_y;
    item_pl.quat_z      = item.quat_z;
    item_pl.quat_w      = item.quat_w;
  end
  assign item.ready = item_ready;
  assign cfg.ready  = 1'b1;

  wft_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .item       (item_pl),
    .st         (dp_st),
    .cmd        (cmd)
  );

  wft_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item_pl),
    .cmd       (cmd),
    .st        (dp_st),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .res       (res),
    .res_valid (result.valid),
    .res_ready (result.ready)
  );

  // Unpack the result transaction
  assign result.cmd_valid           = res.cmd_valid;
  assign result.linear_velocity     = res.linear_velocity;
  assign result.angular_velocity    = res.angular_velocity;
  assign result.waypoint_reached    = res.waypoint_reached;
  assign result.goal_reached        = res.goal_reached;
  assign result.remaining_waypoints = res.remaining_waypoints;

  // Checks
  `WFT_ASSERT_IMP(a_emit_free, cmd.emit, dp_st.out_free, "result emitted over a pending one")
  `WFT_ASSERT_IMP(a_turn_xor_drive, result.valid && result.linear_velocity != 31'd0, result.angular_velocity == 32'sd0, "turn and drive in one command")
  `WFT_ASSERT_IMP(a_arrive_no_cmd, result.valid && result.waypoint_reached, !result.cmd_valid, "command on an arrival tick")
  `WFT_ASSERT_NEXT(a_busy_cordic, cmd.cordic_start, !item.ready, "input taken during angle work")

endmodule
